// ----- rtl/core/csbc_pkg.sv -----
// ----------------------------------------------------------------------------
// csbc_pkg
// Shared types and constants for the clock / stopwatch button controller.
// ----------------------------------------------------------------------------
package csbc_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
   localparam logic [1:0] REG_HOLD_TICKS       = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd2;

   // configuration reset values
   localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
   localparam logic [15:0] HOLD_TICKS_RST       = 16'd1500;
   localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd250;

   // counter limits
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
   localparam logic [4:0]  CLOCK_HOURS   = 5'd24;
   localparam logic [6:0]  WATCH_HOURS   = 7'd100;
   localparam logic [15:0] HOLD_MAX      = 16'hFFFF;

   // display status codes
   localparam logic [1:0] STATUS_RUNNING = 2'd0;
   localparam logic [1:0] STATUS_CLEARED = 2'd1;
   localparam logic [1:0] STATUS_HELD    = 2'd2;
   localparam logic [1:0] STATUS_STOPPED = 2'd3;

   typedef struct packed {
      logic [15:0] ticks_per_second;
      logic [15:0] hold_ticks;
      logic [7:0]  debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [15:0] tick_count;
      logic [5:0]  clk_sec;
      logic [5:0]  clk_min;
      logic [4:0]  clk_hr;
      logic [5:0]  sw_sec;
      logic [5:0]  sw_min;
      logic [6:0]  sw_hr;
      logic        running;
      logic        mode_flag;
      logic [7:0]  lockout_count;
      logic        held_flag;
      logic        press_used;
      logic [15:0] hold_count;
      logic        cleared_flag;
   } state_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic [1:0] display_status;
      logic       show_watch;
      logic       watch_running;
      logic [5:0] watch_second;
      logic [5:0] watch_minute;
      logic [6:0] watch_hour;
      logic [5:0] clock_second;
      logic [5:0] clock_minute;
      logic [4:0] clock_hour;
   } rsp_type;

endpackage

// ----- rtl/core/clock_stopwatch_button_controller.sv -----
// ----------------------------------------------------------------------------
// clock_stopwatch_button_controller
// 24-hour clock and stopwatch driven by millisecond tick transactions.
// ----------------------------------------------------------------------------
// One request transaction is one millisecond tick carrying the stopwatch
// button level and a mode-button edge flag; each one yields exactly one
// response transaction with the clock, the stopwatch, the display mode and
// a display status code. The block takes one tick per clock cycle while
// the response side does not stall: the tick sits in an input register,
// the next state is computed in one pass and written together with the
// response into the output register, and back-pressure on the response
// side stalls the input register. Registers are written
// through the csr port at any time (always ready) and must only change
// while no tick is in flight.
module clock_stopwatch_button_controller
   import csbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: [0] button_pressed, [1] mode_edge, [7:2] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: [4:0] clock_hour, [10:5] clock_minute, [16:11] clock_second,
   // [23:17] watch_hour, [29:24] watch_minute, [35:30] watch_second,
   // [36] watch_running, [37] show_watch, [39:38] display_status
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   rsp_type   rsp_data_ff;
   logic      in_valid_ff;
   logic      in_pressed_ff;
   logic      in_mode_edge_ff;
   logic      rsp_valid_ff;
   logic      advance;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second <= TICKS_PER_SECOND_RST;
         cfg_ff.hold_ticks       <= HOLD_TICKS_RST;
         cfg_ff.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TICKS_PER_SECOND: cfg_ff.ticks_per_second <= csr_data;
            REG_HOLD_TICKS:       cfg_ff.hold_ticks       <= csr_data;
            REG_DEBOUNCE_TICKS:   cfg_ff.debounce_ticks   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   csbc_step u_step (
      .state_i        (state_ff),
      .cfg_i          (cfg_ff),
      .button_pressed (in_pressed_ff),
      .mode_edge      (in_mode_edge_ff),
      .state_o        (state_in),
      .rsp_o          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pressed_ff   <= req_tdata[0];
         in_mode_edge_ff <= req_tdata[1];
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/csbc_step.sv -----
// ----------------------------------------------------------------------------
// csbc_step
// Next-state and result logic for one millisecond tick.
// ----------------------------------------------------------------------------
module csbc_step
   import csbc_pkg::*;
(
   input  state_type state_i,
   input  cfg_type   cfg_i,
   input  logic      button_pressed,
   input  logic      mode_edge,
   output state_type state_o,
   output rsp_type   rsp_o
);

   state_type   s;
   logic [16:0] tick_sum;
   logic        advance_watch;

   always_comb begin
      s = state_i;

      // mode toggle, then lockout decrement
      if (mode_edge && (s.lockout_count == 8'd0)) begin
         s.mode_flag     = ~s.mode_flag;
         s.lockout_count = cfg_i.debounce_ticks;
      end
      if (s.lockout_count != 8'd0) begin
         s.lockout_count = s.lockout_count - 8'd1;
      end

      // tick count and second carry
      advance_watch = s.running;
      tick_sum      = {1'b0, s.tick_count} + 17'd1;
      if (tick_sum >= {1'b0, cfg_i.ticks_per_second}) begin
         s.tick_count = 16'd0;
         if (s.clk_sec == SEC_PER_MIN - 6'd1) begin
            s.clk_sec = 6'd0;
            if (s.clk_min == MIN_PER_HOUR - 6'd1) begin
               s.clk_min = 6'd0;
               s.clk_hr  = (s.clk_hr == CLOCK_HOURS - 5'd1) ? 5'd0 : s.clk_hr + 5'd1;
            end else begin
               s.clk_min = s.clk_min + 6'd1;
            end
         end else begin
            s.clk_sec = s.clk_sec + 6'd1;
         end
         if (advance_watch) begin
            if (s.sw_sec == SEC_PER_MIN - 6'd1) begin
               s.sw_sec = 6'd0;
               if (s.sw_min == MIN_PER_HOUR - 6'd1) begin
                  s.sw_min = 6'd0;
                  s.sw_hr  = (s.sw_hr == WATCH_HOURS - 7'd1) ? 7'd0 : s.sw_hr + 7'd1;
               end else begin
                  s.sw_min = s.sw_min + 6'd1;
               end
            end else begin
               s.sw_sec = s.sw_sec + 6'd1;
            end
         end
      end else begin
         s.tick_count = tick_sum[15:0];
      end

      // stopwatch button
      if (button_pressed) begin
         if (!s.held_flag) begin
            s.held_flag = 1'b1;
            if (s.running) begin
               s.running    = 1'b0;
               s.press_used = 1'b1;
            end else begin
               s.press_used = 1'b0;
            end
         end
         if (!s.running && !s.press_used && !s.cleared_flag) begin
            if (s.hold_count != HOLD_MAX) begin
               s.hold_count = s.hold_count + 16'd1;
            end
            if (s.hold_count >= cfg_i.hold_ticks) begin
               s.sw_hr        = 7'd0;
               s.sw_min       = 6'd0;
               s.sw_sec       = 6'd0;
               s.cleared_flag = 1'b1;
            end
         end
      end else if (s.held_flag) begin
         // release that neither stopped nor cleared starts the watch
         if (!s.running && !s.press_used && !s.cleared_flag) begin
            s.running = 1'b1;
         end
         s.held_flag    = 1'b0;
         s.hold_count   = 16'd0;
         s.press_used   = 1'b0;
         s.cleared_flag = 1'b0;
      end

      state_o = s;

      rsp_o.clock_hour    = s.clk_hr;
      rsp_o.clock_minute  = s.clk_min;
      rsp_o.clock_second  = s.clk_sec;
      rsp_o.watch_hour    = s.sw_hr;
      rsp_o.watch_minute  = s.sw_min;
      rsp_o.watch_second  = s.sw_sec;
      rsp_o.watch_running = s.running;
      rsp_o.show_watch    = s.mode_flag;
      if (s.running) begin
         rsp_o.display_status = STATUS_RUNNING;
      end else if ((s.sw_hr == 7'd0) && (s.sw_min == 6'd0) && (s.sw_sec == 6'd0)) begin
         rsp_o.display_status = STATUS_CLEARED;
      end else if (s.held_flag) begin
         rsp_o.display_status = STATUS_HELD;
      end else begin
         rsp_o.display_status = STATUS_STOPPED;
      end
   end

endmodule

// ----- rtl/core/csbc_checker.sv -----
// ----------------------------------------------------------------------------
// csbc_checker
// Port-level checks for the clock / stopwatch button controller.
// ----------------------------------------------------------------------------
module csbc_checker
   import csbc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // status says running exactly when the watch runs
   a_status_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[36] == (rsp_tdata[39:38] == STATUS_RUNNING)))
      else $error("display status disagrees with watch_running");

   // clock fields stay in range
   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] < CLOCK_HOURS) && (rsp_tdata[10:5] < MIN_PER_HOUR)
                     && (rsp_tdata[16:11] < SEC_PER_MIN))
      else $error("clock field out of range");

   // stopwatch fields stay in range
   a_watch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:17] < WATCH_HOURS) && (rsp_tdata[29:24] < MIN_PER_HOUR)
                     && (rsp_tdata[35:30] < SEC_PER_MIN))
      else $error("stopwatch field out of range");

   // a cleared status means the stopwatch reads zero
   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[39:38] == STATUS_CLEARED) |-> (rsp_tdata[35:17] == 19'd0))
      else $error("cleared status with nonzero stopwatch");

endmodule

bind clock_stopwatch_button_controller csbc_checker u_csbc_checker (.*);
